[hdl/soa_pkg.sv]
`default_nettype none
package soa_pkg;

   // opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NO_SLAB = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;
   localparam logic [1:0] ST_FOREIGN = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_OBJECT_BYTES = 2'd0;
   localparam logic [1:0] CSR_POOL_PAGE    = 2'd1;
   localparam logic [1:0] CSR_PRIME        = 2'd2;

   localparam int CSR_DATA_W = 36;
   localparam int ADDR_W     = 48;
   localparam int OBJ_W      = 12;

   // page and slot geometry; page, queue depth and link are powers of two
   localparam int PAGE_BYTES = 4096;
   localparam int MAX_SLOTS  = 256;
   localparam int LINK_BYTES = 8;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] object_address;
      logic [1:0]        status;
      logic              success;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/slab_object_allocator.sv]
`default_nettype none
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  soa_pkg::req_type
// rsp       out        rsp_valid/rsp_ready  soa_pkg::rsp_type
// csr       in         csr_we (no wait)     index + 36-bit data
//
// One word at a time. Allocate: slab meta read, free queue read, offset
// multiply, address add, after a slab-open step for a newly opened slab.
// Free: page checks, bit-serial offset divide, allocated-bit read, requeue.
// A write of object_bytes reruns the slot geometry (one divide) before the
// next word is taken.
// After reset the slot-allocated memory is swept, all NUM_SLABS*MAX_SLOTS
// entries (rounded up to a power of two), with req_ready low.
// A result waiting in the output register does not block accepting a word.
module slab_object_allocator #(
   parameter int NUM_SLABS    = 8,
   parameter int HEADER_BYTES = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire soa_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output soa_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [soa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PAGE_BYTES = soa_pkg::PAGE_BYTES;
   localparam int MAX_SLOTS  = soa_pkg::MAX_SLOTS;
   localparam int LINK_BYTES = soa_pkg::LINK_BYTES;
   localparam int PBLOG = $clog2(PAGE_BYTES);
   localparam int SW    = $clog2(MAX_SLOTS);
   localparam int SIW   = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int CW    = $clog2(NUM_SLABS + 1);
   localparam int VW    = 13;
   localparam int DW    = (PBLOG + 1 > 13) ? PBLOG + 1 : 13;
   localparam int QAW   = SIW + SW;
   localparam int PRW   = SW + VW;
   localparam int AW    = soa_pkg::ADDR_W;
   localparam int RST_SZ = ((8 + 2 * LINK_BYTES - 1) / LINK_BYTES) * LINK_BYTES;
   localparam int RST_NR = (PAGE_BYTES - HEADER_BYTES) / RST_SZ;
   localparam int RST_N  = (RST_NR > MAX_SLOTS) ? MAX_SLOTS : RST_NR;

   typedef struct packed {
      logic [SW:0]   cnt;
      logic [SW-1:0] head;
      logic [SW-1:0] tail;
      logic [SW-1:0] start;
      logic [SW:0]   wr;
   } meta_type;

   typedef enum logic [12:0] {
      S_CLEAR = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_GEO1  = 13'b0000000000100,
      S_GEO2  = 13'b0000000001000,
      S_ACT   = 13'b0000000010000,
      S_AMETA = 13'b0000000100000,
      S_AQUE  = 13'b0000001000000,
      S_AIDX  = 13'b0000010000000,
      S_AADDR = 13'b0000100000000,
      S_FCHK  = 13'b0001000000000,
      S_FDIV  = 13'b0010000000000,
      S_FRD   = 13'b0100000000000,
      S_RESP  = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [QAW-1:0]     clr_ff, clr_in;
   logic [11:0]        ob_ff, ob_in;
   logic [35:0]        ppn_ff, ppn_in;
   logic [VW-1:0]      sz_ff, sz_in;
   logic [SW:0]        n_ff, n_in;
   logic               geom_pend_ff, geom_pend_in;
   logic               prime_pend_ff, prime_pend_in;
   logic               prime_first_ff, prime_first_in;
   logic [CW-1:0]      created_ff, created_in;
   logic [SIW-1:0]     cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [NUM_SLABS-1:0] nonfull_ff, nonfull_in;
   logic [SIW-1:0]     sel_ff, sel_in;
   logic               act_alloc_ff, act_alloc_in;
   soa_pkg::req_type   req_ff, req_in;
   soa_pkg::rsp_type   res_ff, res_in;
   meta_type           meta_ff, meta_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [PRW-1:0]     prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   soa_pkg::rsp_type   rsp_ff, rsp_in;

   // memories
   logic               meta_we;
   logic [SIW-1:0]     meta_waddr, meta_raddr;
   meta_type           meta_wdata, meta_rdata;
   logic               que_we;
   logic [QAW-1:0]     que_waddr, que_raddr;
   logic [SW-1:0]      que_wdata, que_rdata;
   logic               alc_we;
   logic [QAW-1:0]     alc_waddr, alc_raddr;
   logic               alc_wdata, alc_rdata;

   // divider
   logic               div_start, div_done;
   logic [DW-1:0]      div_dividend, div_quo;
   logic [VW-1:0]      div_divisor, div_rem;

   // scratch
   logic               srch_found;
   logic [SIW-1:0]     srch_slab;
   logic [VW-1:0]      geo_x;
   logic [AW-1:0]      page_addr, rel_page, link_addr, base_addr;
   logic [PBLOG-1:0]   off_rel;
   logic [SW-1:0]      q_rel, q_idx;
   logic               q_written;

   soa_ram #(.WIDTH($bits(meta_type)), .ADDR_BITS(SIW)) u_meta_ram (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
      .rd_addr(meta_raddr), .rd_data(meta_rdata)
   );

   soa_ram #(.WIDTH(SW), .ADDR_BITS(QAW)) u_queue_ram (
      .clock(clock), .wr_en(que_we), .wr_addr(que_waddr), .wr_data(que_wdata),
      .rd_addr(que_raddr), .rd_data(que_rdata)
   );

   soa_ram #(.WIDTH(1), .ADDR_BITS(QAW)) u_alloc_ram (
      .clock(clock), .wr_en(alc_we), .wr_addr(alc_waddr), .wr_data(alc_wdata),
      .rd_addr(alc_raddr), .rd_data(alc_rdata)
   );

   soa_div #(.DW(DW), .VW(VW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quo),
      .remainder(div_rem)
   );

   // first non-full slab in creation order
   always_comb begin
      srch_found = 1'b0;
      srch_slab  = '0;
      for (int i = NUM_SLABS - 1; i >= 0; i--) begin
         if (nonfull_ff[i]) begin
            srch_found = 1'b1;
            srch_slab  = SIW'(i);
         end
      end
   end

   // address arithmetic shared by the paths
   always_comb begin
      geo_x     = VW'(ob_ff) + VW'(2 * LINK_BYTES - 1);
      page_addr = AW'(req_ff.free_address >> PBLOG);
      rel_page  = page_addr - AW'(ppn_ff);
      link_addr = req_ff.free_address - AW'(LINK_BYTES);
      off_rel   = link_addr[PBLOG-1:0] - PBLOG'(HEADER_BYTES);
      base_addr = AW'((64'(ppn_ff) + 64'(sel_ff)) << PBLOG);
      q_rel     = meta_ff.head - meta_ff.start;
      q_written = meta_ff.wr[SW] || ({1'b0, q_rel} < meta_ff.wr);
      q_idx     = q_written ? que_rdata : meta_ff.head;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      ob_in          = ob_ff;
      ppn_in         = ppn_ff;
      sz_in          = sz_ff;
      n_in           = n_ff;
      geom_pend_in   = geom_pend_ff;
      prime_pend_in  = prime_pend_ff;
      prime_first_in = prime_first_ff;
      created_in     = created_ff;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      nonfull_in     = nonfull_ff;
      sel_in         = sel_ff;
      act_alloc_in   = act_alloc_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      meta_in        = meta_ff;
      idx_in         = idx_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      meta_we        = 1'b0;
      meta_waddr     = sel_ff;
      meta_wdata     = meta_ff;
      meta_raddr     = sel_ff;
      que_we         = 1'b0;
      que_waddr      = {sel_ff, meta_rdata.tail};
      que_wdata      = idx_ff;
      que_raddr      = {sel_ff, meta_rdata.head};
      alc_we         = 1'b0;
      alc_waddr      = {sel_ff, idx_ff};
      alc_wdata      = 1'b0;
      alc_raddr      = {sel_ff, idx_ff};
      div_start      = 1'b0;
      div_dividend   = DW'(geo_x);
      div_divisor    = VW'(LINK_BYTES);
      req_ready      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            alc_we    = 1'b1;
            alc_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = !geom_pend_ff && !prime_pend_ff;
            if (geom_pend_ff && !(prime_pend_ff && prime_first_ff)) begin
               geom_pend_in = 1'b0;
               state_in     = S_GEO1;
            end else if (prime_pend_ff) begin
               prime_pend_in = 1'b0;
               if (created_ff == '0) begin
                  sel_in       = '0;
                  act_alloc_in = 1'b0;
                  state_in     = S_ACT;
               end
            end else if (req_valid) begin
               req_in = req_data;
               if (req_data.opcode == soa_pkg::OP_FREE) begin
                  state_in = S_FCHK;
               end else if (cur_valid_ff && nonfull_ff[cur_ff]) begin
                  sel_in   = cur_ff;
                  state_in = S_AMETA;
               end else if (srch_found) begin
                  sel_in       = srch_slab;
                  cur_in       = srch_slab;
                  cur_valid_in = 1'b1;
                  state_in     = S_AMETA;
               end else if (created_ff < CW'(NUM_SLABS)) begin
                  sel_in       = SIW'(created_ff);
                  act_alloc_in = 1'b1;
                  state_in     = S_ACT;
               end else begin
                  res_in   = '{object_address: '0, status: soa_pkg::ST_NO_SLAB,
                               success: 1'b0};
                  state_in = S_RESP;
               end
            end
         end
         S_GEO1: begin
            // slot size: payload plus link, rounded up to whole link words
            sz_in        = geo_x & ~VW'(LINK_BYTES - 1);
            div_start    = 1'b1;
            div_dividend = DW'(PAGE_BYTES - HEADER_BYTES);
            div_divisor  = sz_in;
            state_in     = S_GEO2;
         end
         S_GEO2: begin
            if (div_done) begin
               n_in = (div_quo >= DW'(MAX_SLOTS)) ? (SW + 1)'(MAX_SLOTS)
                                                  : (SW + 1)'(div_quo);
               state_in = S_IDLE;
            end
         end
         S_ACT: begin
            // open a slab: full identity queue, nothing allocated yet
            meta_we          = 1'b1;
            meta_wdata.cnt   = n_ff;
            meta_wdata.head  = '0;
            meta_wdata.tail  = n_ff[SW-1:0];
            meta_wdata.start = n_ff[SW-1:0];
            meta_wdata.wr    = '0;
            nonfull_in[sel_ff] = n_ff != '0;
            created_in   = CW'(sel_ff) + 1'b1;
            cur_in       = sel_ff;
            cur_valid_in = 1'b1;
            if (!act_alloc_ff) begin
               state_in = S_IDLE;
            end else if (n_ff != '0) begin
               state_in = S_AMETA;
            end else begin
               res_in   = '{object_address: '0, status: soa_pkg::ST_NO_SLAB,
                            success: 1'b0};
               state_in = S_RESP;
            end
         end
         S_AMETA: begin
            state_in = S_AQUE;
         end
         S_AQUE: begin
            meta_in  = meta_rdata;
            state_in = S_AIDX;
         end
         S_AIDX: begin
            // pop the head; entries never written since opening hold identity
            idx_in    = q_idx;
            prod_in   = PRW'(q_idx) * PRW'(sz_ff);
            alc_we    = 1'b1;
            alc_waddr = {sel_ff, q_idx};
            alc_wdata = 1'b1;
            meta_we   = 1'b1;
            meta_wdata.head = meta_ff.head + 1'b1;
            meta_wdata.cnt  = meta_ff.cnt - 1'b1;
            nonfull_in[sel_ff] = meta_ff.cnt != (SW + 1)'(1);
            state_in = S_AADDR;
         end
         S_AADDR: begin
            res_in.object_address = base_addr + AW'(HEADER_BYTES + LINK_BYTES)
                                    + AW'(prod_ff);
            res_in.status  = soa_pkg::ST_DONE;
            res_in.success = 1'b1;
            state_in = S_RESP;
         end
         S_FCHK: begin
            // ownership and page-local checks
            sel_in = SIW'(rel_page);
            res_in = '{object_address: '0, status: soa_pkg::ST_REJECT,
                       success: 1'b1};
            if ((page_addr < AW'(ppn_ff)) || (rel_page >= AW'(created_ff))) begin
               res_in.status  = soa_pkg::ST_FOREIGN;
               res_in.success = 1'b0;
               state_in       = S_RESP;
            end else if ((req_ff.free_address < AW'(LINK_BYTES))
                         || (link_addr[AW-1:PBLOG] != req_ff.free_address[AW-1:PBLOG])
                         || (link_addr[PBLOG-1:0] < PBLOG'(HEADER_BYTES))) begin
               state_in = S_RESP;
            end else begin
               div_start    = 1'b1;
               div_dividend = DW'(off_rel);
               div_divisor  = sz_ff;
               state_in     = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               if ((div_rem != '0) || (div_quo >= DW'(n_ff))) begin
                  state_in = S_RESP;
               end else begin
                  idx_in    = div_quo[SW-1:0];
                  alc_raddr = {sel_ff, div_quo[SW-1:0]};
                  state_in  = S_FRD;
               end
            end
         end
         S_FRD: begin
            // requeue at the tail if the slot was allocated
            if (alc_rdata) begin
               alc_we    = 1'b1;
               alc_wdata = 1'b0;
               que_we    = 1'b1;
               meta_we   = 1'b1;
               meta_wdata      = meta_rdata;
               meta_wdata.tail = meta_rdata.tail + 1'b1;
               meta_wdata.cnt  = meta_rdata.cnt + 1'b1;
               meta_wdata.wr   = meta_rdata.wr[SW] ? meta_rdata.wr
                                                   : meta_rdata.wr + 1'b1;
               nonfull_in[sel_ff] = 1'b1;
               res_in.status = soa_pkg::ST_DONE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            soa_pkg::CSR_OBJECT_BYTES: begin
               ob_in        = csr_wdata[11:0];
               geom_pend_in = 1'b1;
            end
            soa_pkg::CSR_POOL_PAGE: begin
               ppn_in = csr_wdata[35:0];
            end
            soa_pkg::CSR_PRIME: begin
               if (csr_wdata[0] && !prime_pend_ff) begin
                  prime_pend_in  = 1'b1;
                  prime_first_in = !geom_pend_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         ob_ff          <= 12'd8;
         ppn_ff         <= '0;
         sz_ff          <= VW'(RST_SZ);
         n_ff           <= (SW + 1)'(RST_N);
         geom_pend_ff   <= 1'b0;
         prime_pend_ff  <= 1'b0;
         prime_first_ff <= 1'b0;
         created_ff     <= '0;
         cur_ff         <= '0;
         cur_valid_ff   <= 1'b0;
         nonfull_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         ob_ff          <= ob_in;
         ppn_ff         <= ppn_in;
         sz_ff          <= sz_in;
         n_ff           <= n_in;
         geom_pend_ff   <= geom_pend_in;
         prime_pend_ff  <= prime_pend_in;
         prime_first_ff <= prime_first_in;
         created_ff     <= created_in;
         cur_ff         <= cur_in;
         cur_valid_ff   <= cur_valid_in;
         nonfull_ff     <= nonfull_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sel_ff       <= sel_in;
      act_alloc_ff <= act_alloc_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      meta_ff      <= meta_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[hdl/soa_ram.sv]
`default_nettype none
module soa_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/soa_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module soa_div #(
   parameter int DW = 13,
   parameter int VW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] quotient,
   output logic      [VW-1:0] remainder
);

   localparam int CNW = $clog2(DW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [VW-1:0]  rem_ff, rem_in;
   logic [VW-1:0]  dvs_ff, dvs_in;
   logic [VW:0]    trial;
   logic [VW:0]    diff;
   logic           ge;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

[hdl/soa_checker.sv]
`default_nettype none
module soa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire soa_pkg::req_type                req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire soa_pkg::rsp_type                rsp_data,
   input wire logic                            csr_we,
   input wire logic [1:0]                      csr_index,
   input wire logic [soa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // a word waiting on the result side stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one word in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted two words back to back");

   // failed allocation gives zero address and no success
   a_no_slab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == soa_pkg::ST_NO_SLAB |->
         !rsp_data.success && rsp_data.object_address == '0)
      else $error("no-slab result malformed");

   // foreign frees never claim success
   a_foreign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == soa_pkg::ST_FOREIGN |->
         !rsp_data.success && rsp_data.object_address == '0)
      else $error("foreign free reported success");

   // rejected frees inside the cache still report success
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == soa_pkg::ST_REJECT |->
         rsp_data.success && rsp_data.object_address == '0)
      else $error("rejected free result malformed");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLAB   = 8;
   localparam int PAGE    = 4096;
   localparam int HDR     = 64;
   localparam int NSLOT   = 256;
   localparam int LINK    = 8;
   localparam int SETTLE  = 200;
   localparam int LIMIT   = 1000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   soa_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   soa_pkg::rsp_type               rsp_data;
   logic                           csr_we = 1'b0;
   logic [1:0]                     csr_index = soa_pkg::CSR_OBJECT_BYTES;
   logic [soa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   slab_object_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // allocator shadow: registers and slab state
   logic [soa_pkg::OBJ_W-1:0] obj_bytes = 12'd8;
   logic [35:0]      pool_page = '0;
   bit               slab_on  [NSLAB];
   int unsigned      free_cnt [NSLAB];
   int unsigned      q_head   [NSLAB];
   int unsigned      q_tail   [NSLAB];
   logic [7:0]       slot_q   [NSLAB*NSLOT];
   bit               slot_busy[NSLAB*NSLOT];
   int unsigned      cur_slab = 0;
   bit               cur_ok = 0;
   int unsigned      created = 0;

   soa_pkg::rsp_type pending_rsp[$];
   logic [47:0]      live_addr[$];
   int               errors = 0;
   int               req_idle_pct = 15;
   int               rsp_idle_pct = 61;
   int               rsp_hold_left = 0;
   int               cycles = 0;

   function automatic longint unsigned slot_bytes();
      return ((64'(obj_bytes) + LINK + LINK - 1) / LINK) * LINK;
   endfunction

   function automatic longint unsigned slot_total();
      longint unsigned n;
      n = (PAGE - HDR) / slot_bytes();
      return (n > NSLOT) ? NSLOT : n;
   endfunction

   function automatic void open_slab(int unsigned s);
      int unsigned n;
      n = int'(slot_total());
      for (int i = 0; i < NSLOT; i++) begin
         slot_q[s*NSLOT+i] = 8'(i);
         slot_busy[s*NSLOT+i] = 0;
      end
      slab_on[s] = 1;
      free_cnt[s] = n;
      q_head[s] = 0;
      q_tail[s] = n % NSLOT;
      created = s + 1;
      cur_slab = s;
      cur_ok = 1;
   endfunction

   // expected answer for one word; updates the shadow state
   function automatic soa_pkg::rsp_type alloc_free_result(soa_pkg::req_type w);
      soa_pkg::rsp_type r;
      int unsigned s, h, ix, t;
      bit found;
      longint unsigned a, pg, rel, lnk, off, sz, idx;
      r = '0;
      a = 64'(w.free_address);
      found = 0;
      s = 0;
      if (w.opcode == soa_pkg::OP_ALLOC) begin
         if (cur_ok && cur_slab < NSLAB && free_cnt[cur_slab] != 0) begin
            s = cur_slab;
            found = 1;
         end else begin
            for (int i = 0; i < created && i < NSLAB; i++)
               if (!found && slab_on[i] && free_cnt[i] != 0) begin
                  s = i;
                  found = 1;
               end
            if (found) begin
               cur_slab = s;
               cur_ok = 1;
            end else if (created < NSLAB) begin
               s = created;
               open_slab(s);
               found = free_cnt[s] != 0;
            end
         end
         if (!found) begin
            r.status = soa_pkg::ST_NO_SLAB;
            return r;
         end
         h = q_head[s] % NSLOT;
         ix = slot_q[s*NSLOT+h];
         q_head[s] = (h + 1) % NSLOT;
         free_cnt[s]--;
         slot_busy[s*NSLOT+ix] = 1;
         pg = (64'(pool_page) + 64'(s)) * PAGE;
         r.object_address = 48'(pg + HDR + 64'(ix) * slot_bytes() + LINK);
         r.status = soa_pkg::ST_DONE;
         r.success = 1'b1;
         return r;
      end
      // free path
      pg = a / PAGE;
      if (pg < 64'(pool_page)) begin
         r.status = soa_pkg::ST_FOREIGN;
         return r;
      end
      rel = pg - 64'(pool_page);
      if (rel >= created || rel >= NSLAB || !slab_on[rel]) begin
         r.status = soa_pkg::ST_FOREIGN;
         return r;
      end
      s = int'(rel);
      r.success = 1'b1;
      r.status = soa_pkg::ST_REJECT;
      if (a < LINK) return r;
      lnk = a - LINK;
      if (lnk / PAGE != pg) return r;
      off = lnk % PAGE;
      if (off < HDR) return r;
      sz = slot_bytes();
      if ((off - HDR) % sz != 0) return r;
      idx = (off - HDR) / sz;
      if (idx >= slot_total() || idx >= NSLOT) return r;
      if (!slot_busy[s*NSLOT+idx]) return r;
      slot_busy[s*NSLOT+idx] = 0;
      t = q_tail[s] % NSLOT;
      slot_q[s*NSLOT+t] = 8'(idx);
      q_tail[s] = (t + 1) % NSLOT;
      free_cnt[s]++;
      r.status = soa_pkg::ST_DONE;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // stop offering, wait for all results, then let background work finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [soa_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         soa_pkg::CSR_OBJECT_BYTES: obj_bytes = val[soa_pkg::OBJ_W-1:0];
         soa_pkg::CSR_POOL_PAGE:    pool_page = val;
         soa_pkg::CSR_PRIME:        if (val[0] && created == 0) open_slab(0);
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(soa_pkg::req_type w, bit typed, soa_pkg::rsp_type typed_rsp);
      soa_pkg::rsp_type pred;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      pred = alloc_free_result(w);
      pending_rsp.push_back(typed ? typed_rsp : pred);
      if (w.opcode == soa_pkg::OP_ALLOC && pred.status == soa_pkg::ST_DONE)
         live_addr.push_back(pred.object_address);
   endtask

   function automatic soa_pkg::req_type random_word(int alloc_pct, int free_pct);
      soa_pkg::req_type w;
      int pick;
      int unsigned k;
      pick = $urandom_range(0, 99);
      w.free_address = 48'({$urandom(), $urandom()});
      if (pick < alloc_pct) begin
         w.opcode = soa_pkg::OP_ALLOC;
      end else if (pick < alloc_pct + free_pct && live_addr.size() != 0) begin
         w.opcode = soa_pkg::OP_FREE;
         k = $urandom_range(0, live_addr.size() - 1);
         w.free_address = live_addr[k];
         live_addr.delete(k);
      end else begin
         w.opcode = soa_pkg::OP_FREE;
         if ($urandom_range(0, 1))
            w.free_address = 48'((64'(pool_page) + $urandom_range(0, NSLAB)) * PAGE
                                 + $urandom_range(0, PAGE - 1));
      end
      return w;
   endfunction

   task automatic run_phase(int count, int alloc_pct, int free_pct);
      for (int n = 0; n < count; n++)
         send_word(random_word(alloc_pct, free_pct), 1'b0, '0);
   endtask

   typedef struct {
      logic             op;
      logic [47:0]      addr;
      bit               typed;
      soa_pkg::rsp_type want;
   } dir_row;

   // default geometry, slab zero primed: 16-byte slots, objects from 72 up
   dir_row plan [0:15] = '{
      '{soa_pkg::OP_FREE,  48'h0000_0000_1000, 1, '{48'h0, soa_pkg::ST_FOREIGN, 1'b0}},
      '{soa_pkg::OP_FREE,  48'hFFFF_FFFF_FFFF, 1, '{48'h0, soa_pkg::ST_FOREIGN, 1'b0}},
      '{soa_pkg::OP_ALLOC, 48'hFFFF_FFFF_FFFF, 1, '{48'd72, soa_pkg::ST_DONE, 1'b1}},
      '{soa_pkg::OP_ALLOC, 48'h0,              1, '{48'd88, soa_pkg::ST_DONE, 1'b1}},
      '{soa_pkg::OP_FREE,  48'd72,             1, '{48'h0, soa_pkg::ST_DONE, 1'b1}},
      '{soa_pkg::OP_FREE,  48'd72,             1, '{48'h0, soa_pkg::ST_REJECT, 1'b1}},
      '{soa_pkg::OP_FREE,  48'd0,              1, '{48'h0, soa_pkg::ST_REJECT, 1'b1}},
      '{soa_pkg::OP_FREE,  48'd8,              1, '{48'h0, soa_pkg::ST_REJECT, 1'b1}},
      '{soa_pkg::OP_FREE,  48'd80,             1, '{48'h0, soa_pkg::ST_REJECT, 1'b1}},
      '{soa_pkg::OP_FREE,  48'h0000_0000_0FFF, 0, '{48'h0, soa_pkg::ST_DONE, 1'b0}},
      '{soa_pkg::OP_FREE,  48'h0000_0000_1004, 1, '{48'h0, soa_pkg::ST_FOREIGN, 1'b0}},
      '{soa_pkg::OP_FREE,  48'd88,             1, '{48'h0, soa_pkg::ST_DONE, 1'b1}},
      '{soa_pkg::OP_ALLOC, 48'h0,              0, '{48'h0, soa_pkg::ST_DONE, 1'b0}},
      '{soa_pkg::OP_ALLOC, 48'h0,              0, '{48'h0, soa_pkg::ST_DONE, 1'b0}},
      '{soa_pkg::OP_FREE,  48'd4088,           0, '{48'h0, soa_pkg::ST_DONE, 1'b0}},
      '{soa_pkg::OP_FREE,  48'h0010_0000_0000, 0, '{48'h0, soa_pkg::ST_DONE, 1'b0}}
   };

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.object_address, 48'h0);
         end else begin
            if (rsp_data.object_address !== pending_rsp[0].object_address)
               report_mismatch("object_address", rsp_data.object_address,
                               pending_rsp[0].object_address);
            if (rsp_data.status !== pending_rsp[0].status)
               report_mismatch("status", 48'(rsp_data.status), 48'(pending_rsp[0].status));
            if (rsp_data.success !== pending_rsp[0].success)
               report_mismatch("success", 48'(rsp_data.success), 48'(pending_rsp[0].success));
            void'(pending_rsp.pop_front());
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd8);
      write_reg(soa_pkg::CSR_POOL_PAGE, 36'd0);
      write_reg(soa_pkg::CSR_PRIME, 36'd1);

      // directed rows
      foreach (plan[i]) begin
         soa_pkg::req_type w;
         w.opcode = plan[i].op;
         w.free_address = plan[i].addr;
         send_word(w, plan[i].typed, plan[i].want);
      end
      settle();

      // drain slab zero under the output hold-off, opening slab one
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd24);
      write_reg(soa_pkg::CSR_PRIME, 36'd0);
      rsp_hold_left = 3000;
      run_phase(400, 85, 10);
      settle();

      // two slots per page: open slabs quickly
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd2000);
      write_reg(soa_pkg::CSR_POOL_PAGE, 36'h40);
      n = 0;
      while (created < 5 && n < 300) begin
         send_word(random_word(100, 0), 1'b0, '0);
         n++;
      end
      settle();

      // slot larger than a page: empty slabs, then pool exhausted
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd4095);
      run_phase(40, 100, 0);
      settle();

      req_idle_pct = 61;
      rsp_idle_pct = 15;
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd4024);
      write_reg(soa_pkg::CSR_POOL_PAGE, 36'hF_FFFF_FFFF);
      run_phase(300, 45, 45);
      settle();

      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd1);
      write_reg(soa_pkg::CSR_POOL_PAGE, 36'd0);
      write_reg(soa_pkg::CSR_PRIME, 36'd1);
      run_phase(400, 50, 40);
      settle();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd24);
      run_phase(400, 45, 45);
      settle();

      write_reg(soa_pkg::CSR_OBJECT_BYTES, 36'd56);
      write_reg(soa_pkg::CSR_POOL_PAGE, 36'h40);
      run_phase(300, 50, 40);

      req_valid <= 1'b0;
      settle();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
